// File: design/matrix_times_transpose_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for matrix_times_transpose
// Short forms of the concurrent checks used in the top level.
// ----------------------------------------------------------------------------
`ifndef MATRIX_TIMES_TRANSPOSE_DEFINES_SVH
`define MATRIX_TIMES_TRANSPOSE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while in reset.
`define MTT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while in reset.
`define MTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Types, widths and codes shared by the matrix_times_transpose files.
// ----------------------------------------------------------------------------
`default_nettype none

package mtt_pkg;

	localparam int MTT_MAX_OUTPUTS = 16;
	localparam int MTT_MAX_INNER   = 16;
	// The index fields are four bits wide, so at most sixteen rows and columns.
	localparam int FIELD_LIMIT     = 16;

	localparam int VALUE_W = 16;
	localparam int PROD_W  = 32;
	localparam int SUM_W   = 40;
	localparam int IDX_W   = 4;
	localparam int ROWNUM_W = 16;
	localparam int REG_W   = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [REG_W-1:0] REG_RESET = 5'd16;

	localparam logic [CFG_IDX_W-1:0] REG_INNER_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 1'b1;

	localparam logic OP_WRITE_B  = 1'b0;
	localparam logic OP_STREAM_A = 1'b1;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic             adv;      // pipeline moves this cycle
		logic             acc_go;   // stage-2 element is accumulated
		logic             row_end;  // stage-2 element closes the row
		logic             shift;    // result chain moves one place
		logic [REG_W-1:0] nout;     // B rows in use
	} mtt_ctl_t;

	// One result slot of the chain.
	typedef struct packed {
		logic                    valid;
		logic                    last;
		logic [IDX_W-1:0]        col;
		logic signed [SUM_W-1:0] sum;
	} mtt_res_t;

endpackage

`default_nettype wire

// File: design/mtt_item_if.sv
// ----------------------------------------------------------------------------
// mtt_item_if
// Input channel: B writes and A elements, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtt_item_if import mtt_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [IDX_W-1:0]          b_row;
	logic [IDX_W-1:0]          inner_index;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, operation, b_row, inner_index, value, input ready);
	modport sink (input valid, operation, b_row, inner_index, value, output ready);
endinterface

`default_nettype wire

// File: design/mtt_result_if.sv
// ----------------------------------------------------------------------------
// mtt_result_if
// Output channel: one dot product per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtt_result_if import mtt_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [ROWNUM_W-1:0]     a_row_number;
	logic [IDX_W-1:0]        b_row_number;
	logic signed [SUM_W-1:0] dot_sum;
	logic                    last;

	modport source (output valid, a_row_number, b_row_number, dot_sum, last, input ready);
	modport sink (input valid, a_row_number, b_row_number, dot_sum, last, output ready);
endinterface

`default_nettype wire

// File: design/matrix_times_transpose.sv
// ----------------------------------------------------------------------------
// matrix_times_transpose
// Streaming C = A * transpose(B) over a row of per-B-row cells.
// ----------------------------------------------------------------------------
// Each B row lives in its own cell with a small RAM, a 16x16 multiplier and a
// 40-bit accumulator. B elements and A elements share one input channel and
// are taken at one beat per clock unless stalled. An A element is broadcast
// to all cells; the RAM read, multiply and accumulate are each registered,
// and a row's results start leaving once its closing element has passed them.
// The results of a row are loaded into the cells' result slots and shift
// toward cell 0, one beat per clock while the output is ready, B row 0 first.
// The closing element of the next row waits in the accumulate stage until the
// chain is empty, so the input rate is one element per cycle while rows have
// more elements than B rows in use, else it is bounded by the output_count
// beats per row the chain needs. The B store has no reset or clearing pass.
`default_nettype none

`include "matrix_times_transpose_defines.svh"

module matrix_times_transpose import mtt_pkg::*; #(
	parameter int MAX_OUTPUTS = MTT_MAX_OUTPUTS,
	parameter int MAX_INNER   = MTT_MAX_INNER
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	mtt_item_if.sink                  items,
	mtt_result_if.source              results
);

	localparam int NCELL = (MAX_OUTPUTS < FIELD_LIMIT) ? MAX_OUTPUTS : FIELD_LIMIT;
	localparam int NINNER = (MAX_INNER < FIELD_LIMIT) ? MAX_INNER : FIELD_LIMIT;
	localparam int AW = (NINNER > 1) ? $clog2(NINNER) : 1;

	logic [REG_W-1:0] inner_length_q;
	logic [REG_W-1:0] output_count_q;
	logic [REG_W-1:0] nin;
	logic [REG_W-1:0] nout;

	logic accept;
	logic b_wr;
	logic a_go;
	logic stall;

	logic                      v_s1;
	logic                      end_s1;
	logic signed [VALUE_W-1:0] a_s1;
	logic                      v_s2;
	logic                      end_s2;

	logic [ROWNUM_W-1:0] row_q;
	logic [ROWNUM_W-1:0] chain_row_q;

	mtt_ctl_t         ctl;
	mtt_res_t         res [NCELL+1];
	logic [NCELL-1:0] slot_valid;
	logic             busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_length_q <= REG_RESET;
			output_count_q <= REG_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_INNER_LENGTH: inner_length_q <= cfg_data;
				REG_OUTPUT_COUNT: output_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero register acts as one; a value beyond capacity saturates.
	always_comb begin
		if (inner_length_q == '0) begin
			nin = REG_W'(1);
		end else if (inner_length_q > REG_W'(NINNER)) begin
			nin = REG_W'(NINNER);
		end else begin
			nin = inner_length_q;
		end
		if (output_count_q == '0) begin
			nout = REG_W'(1);
		end else if (output_count_q > REG_W'(NCELL)) begin
			nout = REG_W'(NCELL);
		end else begin
			nout = output_count_q;
		end
	end

	assign busy  = |slot_valid;
	assign stall = v_s2 && end_s2 && busy;

	assign items.ready = !stall;
	assign accept      = items.valid && items.ready;
	assign b_wr = accept && (items.operation == OP_WRITE_B)
		&& ({1'b0, items.b_row} < REG_W'(NCELL))
		&& ({1'b0, items.inner_index} < REG_W'(NINNER));
	assign a_go = accept && (items.operation == OP_STREAM_A)
		&& ({1'b0, items.inner_index} < nin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			end_s1 <= 1'b0;
			v_s2   <= 1'b0;
			end_s2 <= 1'b0;
		end else if (!stall) begin
			v_s1   <= a_go;
			end_s1 <= {1'b0, items.inner_index} == (nin - REG_W'(1));
			v_s2   <= v_s1;
			end_s2 <= end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			a_s1 <= items.value;
		end
	end

	always_comb begin
		ctl.adv     = !stall;
		ctl.acc_go  = !stall && v_s2;
		ctl.row_end = end_s2;
		ctl.shift   = !res[0].valid || results.ready;
		ctl.nout    = nout;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			chain_row_q <= '0;
		end else if (ctl.acc_go && ctl.row_end) begin
			row_q       <= row_q + ROWNUM_W'(1);
			chain_row_q <= row_q;
		end
	end

	assign res[NCELL] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		mtt_cell #(.IDX(i), .DEPTH(NINNER)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.wr_en   (b_wr && (items.b_row == IDX_W'(i))),
			.wr_addr (items.inner_index[AW-1:0]),
			.wr_data (items.value),
			.rd_en   (a_go),
			.rd_addr (items.inner_index[AW-1:0]),
			.a_s1    (a_s1),
			.res_in  (res[i+1]),
			.res_q   (res[i])
		);
		assign slot_valid[i] = res[i].valid;
	end

	assign results.valid        = res[0].valid;
	assign results.a_row_number = chain_row_q;
	assign results.b_row_number = res[0].col;
	assign results.dot_sum      = res[0].sum;
	assign results.last         = res[0].last;

	`MTT_ASSERT_NOW(a_load_empty, ctl.acc_go && ctl.row_end, !busy,
		"row results loaded into a busy result chain")
	`MTT_ASSERT_NEXT(a_load_shows, ctl.acc_go && ctl.row_end, results.valid,
		"loaded row shows no result beat")
	`MTT_ASSERT_NOW(a_last_alone, results.valid && results.last, $countones(slot_valid) == 1,
		"last beat leaves further results in the chain")
	`MTT_ASSERT_NEXT(a_row_step, ctl.acc_go && ctl.row_end,
		row_q == $past(row_q) + ROWNUM_W'(1), "row counter did not advance by one")

endmodule

`default_nettype wire

// File: design/mtt_ram.sv
// ----------------------------------------------------------------------------
// mtt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/mtt_cell.sv
// ----------------------------------------------------------------------------
// mtt_cell
// One B row: its store, a multiplier, an accumulator and a result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_cell import mtt_pkg::*; #(
	parameter int IDX   = 0,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mtt_ctl_t                  ctl,
	input  wire logic                      wr_en,
	input  wire logic [AW-1:0]             wr_addr,
	input  wire logic [VALUE_W-1:0]        wr_data,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             rd_addr,
	input  wire logic signed [VALUE_W-1:0] a_s1,
	input  wire mtt_res_t                  res_in,
	output mtt_res_t                       res_q
);

	logic [VALUE_W-1:0]       b_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sum;
	logic                     in_use;
	logic                     is_last;

	mtt_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (b_s1)
	);

	assign in_use  = REG_W'(IDX) < ctl.nout;
	assign is_last = REG_W'(IDX) == (ctl.nout - REG_W'(1));
	assign sum     = acc_q + {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			prod_s2 <= a_s1 * $signed(b_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_go) begin
			if (ctl.row_end) begin
				acc_q <= '0;
			end else if (in_use) begin
				acc_q <= sum;
			end
		end
	end

	// A finished row is loaded only into an empty chain, so load and shift
	// never compete for a slot that holds data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q.valid <= 1'b0;
			res_q.last  <= 1'b0;
			res_q.col   <= '0;
			res_q.sum   <= '0;
		end else if (ctl.acc_go && ctl.row_end) begin
			res_q.valid <= in_use;
			res_q.last  <= in_use && is_last;
			res_q.col   <= IDX_W'(IDX);
			res_q.sum   <= sum;
		end else if (ctl.shift) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire
